// ----- hw/rtl/plit_pkg.sv -----
// plit_pkg: shared types and codes for the piecewise-linear interpolation table
// used by piecewise_linear_table_interp, plit_table and plit_div; no dependencies
`default_nettype none

package plit_pkg;

   localparam int KEY_W   = 16;
   localparam int VAL_W   = 16;
   localparam int CMD_W   = 2;
   localparam int STAT_W  = 2;
   localparam int ENTRY_W = 6;
   localparam int PROD_W  = 32;   // |dv| * |da| fits 16 x 16 bits
   localparam int DEN_W   = 16;
   localparam int QUO_W   = 16;

   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

   localparam logic [STAT_W-1:0] STAT_OK         = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NO_SEGMENT = 2'd1;
   localparam logic [STAT_W-1:0] STAT_NOT_ASCEND = 2'd2;
   localparam logic [STAT_W-1:0] STAT_FULL       = 2'd3;

   typedef struct packed {
      logic        [CMD_W-1:0] cmd;
      logic signed [KEY_W-1:0] point_key;
      logic signed [VAL_W-1:0] point_value;
      logic signed [KEY_W-1:0] query_angle;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0]   coefficient;
      logic        [STAT_W-1:0]  status;
      logic        [ENTRY_W-1:0] entry_count;
   } rsp_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic signed [VAL_W-1:0] value;
   } entry_type;

endpackage

`default_nettype wire

// ----- hw/rtl/piecewise_linear_table_interp.sv -----
// piecewise_linear_table_interp: top level, command sequencer, scan and interpolation
// depends on plit_pkg, plit_table and plit_div
`default_nettype none

// usage
//   req channel: drive req_data and raise start; the beat is taken on a rising
//   edge where start is high and busy is low. cmd clear empties the table,
//   cmd append adds a breakpoint at the end (strictly ascending keys only),
//   cmd query interpolates at query_angle.
//   rsp channel: exactly one result beat per request, marked by rsp_valid for
//   one cycle; the receiver has no way to stall and must take it then.
// sequencing
//   clear, append and the unused command: the result is registered in the cycle
//   after the request, busy stays low, so a new request can follow every cycle.
//   query: a sequential scan of the breakpoint memory, one entry per cycle
//   through its single registered read port, then a multiply step and a
//   restoring divider. A hit goes on to the multiply and the divider; a miss
//   ends after the last entry is read; a table below two points answers
//   without a scan and without raising busy.
//   busy is high for the whole scan, multiply and divide.
// reset
//   synchronous, active high; the table empties (point count zero), no result
//   is pending. Memory contents are not cleared and are never used unwritten.

module piecewise_linear_table_interp #(
   parameter int TABLE_DEPTH = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire plit_pkg::req_type req_data,
   output logic                   rsp_valid,
   output plit_pkg::rsp_type      rsp_data
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_FIRST = 3'd1;   // entry 0 arriving from memory
   localparam logic [2:0] S_SCAN  = 3'd2;   // entry idx arriving, test segment idx-1..idx
   localparam logic [2:0] S_MUL   = 3'd3;   // form |dv| * da and denominator
   localparam logic [2:0] S_LOAD  = 3'd4;   // kick the divider
   localparam logic [2:0] S_DIV   = 3'd5;   // wait for quotient

   logic [2:0]                        state_ff, state_in;
   logic [CW-1:0]                     count_ff, count_in;
   logic signed [plit_pkg::KEY_W-1:0] last_key_ff, last_key_in;
   logic signed [plit_pkg::KEY_W-1:0] angle_ff, angle_in;
   logic [AW-1:0]                     idx_ff, idx_in;
   logic signed [plit_pkg::KEY_W-1:0] k0_ff, k0_in, k1_ff, k1_in;
   logic signed [plit_pkg::VAL_W-1:0] v0_ff, v0_in, v1_ff, v1_in;
   logic [plit_pkg::PROD_W-1:0]       prod_ff, prod_in;
   logic [plit_pkg::DEN_W-1:0]        den_ff, den_in;
   logic                              neg_ff, neg_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   plit_pkg::rsp_type                 rsp_ff, rsp_in;

   // memory and divider hookup
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   plit_pkg::entry_type   wr_data;
   logic [AW-1:0]         rd_addr;
   plit_pkg::entry_type   rd_data;
   logic                  div_start;
   logic                  div_done;
   logic [plit_pkg::QUO_W-1:0] div_quo;

   // arithmetic on the held segment
   logic [plit_pkg::VAL_W:0]   dv;
   logic [plit_pkg::VAL_W:0]   dv_mag;
   logic [plit_pkg::KEY_W:0]   da;
   logic [plit_pkg::KEY_W:0]   dk;
   logic [plit_pkg::VAL_W:0]   q_signed;
   logic [plit_pkg::VAL_W:0]   coef_sum;
   logic [CW-1:0]              idx_next;
   logic                       accept;
   logic                       in_segment;

   plit_table #(
      .DEPTH (TABLE_DEPTH),
      .AW    (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   plit_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (den_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign accept    = start && (state_ff == S_IDLE);
   assign div_start = (state_ff == S_LOAD);

   // signed differences, one bit wider so nothing overflows
   assign dv       = {v1_ff[plit_pkg::VAL_W-1], v1_ff} - {v0_ff[plit_pkg::VAL_W-1], v0_ff};
   assign dv_mag   = dv[plit_pkg::VAL_W] ? (~dv + 1'b1) : dv;
   assign da       = {angle_ff[plit_pkg::KEY_W-1], angle_ff} - {k0_ff[plit_pkg::KEY_W-1], k0_ff};
   assign dk       = {k1_ff[plit_pkg::KEY_W-1], k1_ff} - {k0_ff[plit_pkg::KEY_W-1], k0_ff};
   assign q_signed = neg_ff ? (~{1'b0, div_quo} + 1'b1) : {1'b0, div_quo};
   assign coef_sum = {v0_ff[plit_pkg::VAL_W-1], v0_ff} + q_signed;
   assign idx_next = CW'(idx_ff) + CW'(1);
   assign in_segment = (angle_ff >= k0_ff) && (angle_ff <= rd_data.key);

   always_comb begin
      unique case (state_ff)
         S_FIRST: rd_addr = AW'(1);
         S_SCAN:  rd_addr = idx_ff + 1'b1;
         default: rd_addr = '0;   // entry 0 is prefetched while idle
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      last_key_in  = last_key_ff;
      angle_in     = angle_ff;
      idx_in       = idx_ff;
      k0_in        = k0_ff;
      v0_in        = v0_ff;
      k1_in        = k1_ff;
      v1_in        = v1_ff;
      prod_in      = prod_ff;
      den_in       = den_ff;
      neg_in       = neg_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff[AW-1:0];
      wr_data.key   = req_data.point_key;
      wr_data.value = req_data.point_value;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_in.coefficient = '0;
               rsp_in.status      = plit_pkg::STAT_OK;
               priority if (req_data.cmd == plit_pkg::CMD_CLEAR) begin
                  count_in     = '0;
                  rsp_valid_in = 1'b1;
               end else if (req_data.cmd == plit_pkg::CMD_APPEND) begin
                  rsp_valid_in = 1'b1;
                  priority if (count_ff >= CW'(TABLE_DEPTH)) begin
                     rsp_in.status = plit_pkg::STAT_FULL;
                  end else if ((count_ff != '0) && (req_data.point_key <= last_key_ff)) begin
                     rsp_in.status = plit_pkg::STAT_NOT_ASCEND;
                  end else begin
                     wr_en       = 1'b1;
                     count_in    = count_ff + 1'b1;
                     last_key_in = req_data.point_key;
                  end
               end else if (req_data.cmd == plit_pkg::CMD_QUERY) begin
                  angle_in = req_data.query_angle;
                  if (count_ff < CW'(2)) begin
                     rsp_in.status = plit_pkg::STAT_NO_SEGMENT;
                     rsp_valid_in  = 1'b1;
                  end else begin
                     state_in = S_FIRST;
                  end
               end else begin
                  // unused command: no change, plain ok beat
                  rsp_valid_in = 1'b1;
               end
               rsp_in.entry_count = plit_pkg::ENTRY_W'(count_in);
            end
         end
         S_FIRST: begin
            k0_in    = rd_data.key;
            v0_in    = rd_data.value;
            idx_in   = AW'(1);
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (in_segment) begin
               k1_in    = rd_data.key;
               v1_in    = rd_data.value;
               state_in = S_MUL;
            end else if (idx_next >= count_ff) begin
               // ran off the end of the table
               rsp_in.coefficient = '0;
               rsp_in.status      = plit_pkg::STAT_NO_SEGMENT;
               rsp_in.entry_count = plit_pkg::ENTRY_W'(count_ff);
               rsp_valid_in       = 1'b1;
               state_in           = S_IDLE;
            end else begin
               k0_in  = rd_data.key;
               v0_in  = rd_data.value;
               idx_in = idx_ff + 1'b1;
            end
         end
         S_MUL: begin
            prod_in  = dv_mag[plit_pkg::VAL_W-1:0] * da[plit_pkg::KEY_W-1:0];
            den_in   = dk[plit_pkg::KEY_W-1:0];
            neg_in   = dv[plit_pkg::VAL_W];
            state_in = S_LOAD;
         end
         S_LOAD: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               rsp_in.coefficient = coef_sum[plit_pkg::VAL_W-1:0];
               rsp_in.status      = plit_pkg::STAT_OK;
               rsp_in.entry_count = plit_pkg::ENTRY_W'(count_ff);
               rsp_valid_in       = 1'b1;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_key_ff <= last_key_in;
      angle_ff    <= angle_in;
      idx_ff      <= idx_in;
      k0_ff       <= k0_in;
      v0_ff       <= v0_in;
      k1_ff       <= k1_in;
      v1_ff       <= v1_in;
      prod_ff     <= prod_in;
      den_ff      <= den_in;
      neg_ff      <= neg_in;
      rsp_ff      <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // point count never passes the table size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("point count beyond table depth");

   // a scan only runs on a table with a segment, and stays inside it
   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> ((count_ff >= CW'(2)) && (CW'(idx_ff) < count_ff)))
      else $error("scan index outside the filled table");

   // the divider only finishes while the sequencer waits for it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("divider finished outside the divide step");

   // any beat that is not ok carries a zero coefficient
   a_zero_coef: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status != plit_pkg::STAT_OK)) |-> (rsp_ff.coefficient == '0))
      else $error("nonzero coefficient on a failing beat");

   // a query that was taken on a table of two or more points raises busy
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.cmd == plit_pkg::CMD_QUERY) && (count_ff >= CW'(2)))
         |=> busy)
      else $error("query taken without going busy");

endmodule

`default_nettype wire

// ----- hw/rtl/plit_table.sv -----
// plit_table: breakpoint memory, one write port and one registered read port
// depends on plit_pkg for the entry type
`default_nettype none

module plit_table #(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  wire logic                clock,
   input  wire logic                wr_en,
   input  wire logic [AW-1:0]       wr_addr,
   input  wire plit_pkg::entry_type wr_data,
   input  wire logic [AW-1:0]       rd_addr,
   output plit_pkg::entry_type      rd_data
);

   plit_pkg::entry_type mem [DEPTH];
   plit_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/plit_div.sv -----
// plit_div: restoring divider, one quotient bit per cycle
// depends on plit_pkg for operand widths
`default_nettype none

module plit_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [plit_pkg::PROD_W-1:0]   dividend,
   input  wire logic [plit_pkg::DEN_W-1:0]    divisor,
   output logic                               done,
   output logic [plit_pkg::QUO_W-1:0]         quotient
);

   localparam int CNT_W = $clog2(plit_pkg::PROD_W);

   logic                         run_ff, run_in;
   logic                         done_ff, done_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic [plit_pkg::PROD_W-1:0]  dvd_ff, dvd_in;   // dividend shifts out, quotient in
   logic [plit_pkg::DEN_W-1:0]   rem_ff, rem_in;
   logic [plit_pkg::DEN_W-1:0]   dsr_ff, dsr_in;
   logic [plit_pkg::DEN_W:0]     rem_shift;
   logic [plit_pkg::DEN_W:0]     rem_sub;

   always_comb begin
      rem_shift = {rem_ff, dvd_ff[plit_pkg::PROD_W-1]};
      rem_sub   = rem_shift - {1'b0, dsr_ff};
      run_in    = run_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      dvd_in    = dvd_ff;
      rem_in    = rem_ff;
      dsr_in    = dsr_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = CNT_W'(plit_pkg::PROD_W - 1);
         dvd_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
      end else if (run_ff) begin
         if (!rem_sub[plit_pkg::DEN_W]) begin
            rem_in = rem_sub[plit_pkg::DEN_W-1:0];
            dvd_in = {dvd_ff[plit_pkg::PROD_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[plit_pkg::DEN_W-1:0];
            dvd_in = {dvd_ff[plit_pkg::PROD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff[plit_pkg::QUO_W-1:0];

endmodule

`default_nettype wire

// ----- tb/sv/piecewise_linear_table_interp_tb.sv -----
// piecewise_linear_table_interp_tb: self-checking bench for the breakpoint table interpolator
// sends clear, append and query beats, predicts every result beat and checks it field by field
// depends on plit_pkg and piecewise_linear_table_interp
`timescale 1ns / 100ps

module piecewise_linear_table_interp_tb;

   localparam int TABLE_DEPTH = 32;
   // the command code the block leaves unused: answers ok, changes nothing
   localparam logic [plit_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;
   // leave room past the longest query
   localparam int SETTLE_CYCLES = 100;
   localparam int DRAIN_GUARD   = 2000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   plit_pkg::req_type req_data = '0;
   logic              rsp_valid;
   plit_pkg::rsp_type rsp_data;

   // bench copy of the breakpoint table
   logic signed [plit_pkg::KEY_W-1:0] bp_keys   [TABLE_DEPTH];
   logic signed [plit_pkg::VAL_W-1:0] bp_values [TABLE_DEPTH];
   int                                bp_count = 0;

   plit_pkg::rsp_type pending_results [$];
   plit_pkg::rsp_type oldest_result;
   int                mismatch_count   = 0;
   int                items_accepted   = 0;
   int                sender_idle_pct  = 0;

   piecewise_linear_table_interp #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("%0t ns: mismatch: %s", $time, what);
   endtask

   // expected result of one accepted beat; updates the bench table
   function automatic plit_pkg::rsp_type predict_interp(input plit_pkg::req_type item);
      plit_pkg::rsp_type                 r;
      logic signed [plit_pkg::KEY_W-1:0] angle;
      logic signed [plit_pkg::KEY_W-1:0] key;
      longint                            num;
      longint                            den;
      bit                                hit;
      int                                i;
      r        = '0;
      r.status = plit_pkg::STAT_OK;
      case (item.cmd)
         plit_pkg::CMD_CLEAR: begin
            bp_count = 0;
         end
         plit_pkg::CMD_APPEND: begin
            key = $signed(item.point_key);
            // full check wins over the ordering check
            if (bp_count >= TABLE_DEPTH) begin
               r.status = plit_pkg::STAT_FULL;
            end else if (bp_count > 0 && key <= bp_keys[bp_count - 1]) begin
               r.status = plit_pkg::STAT_NOT_ASCEND;
            end else begin
               bp_keys[bp_count]   = key;
               bp_values[bp_count] = $signed(item.point_value);
               bp_count++;
            end
         end
         plit_pkg::CMD_QUERY: begin
            angle    = $signed(item.query_angle);
            r.status = plit_pkg::STAT_NO_SEGMENT;
            hit      = 1'b0;
            // first segment wins, so an inner key uses the segment ending there
            for (i = 0; i + 1 < bp_count && !hit; i++) begin
               if (angle >= bp_keys[i] && angle <= bp_keys[i + 1]) begin
                  num = (longint'(bp_values[i + 1]) - longint'(bp_values[i]))
                        * (longint'(angle) - longint'(bp_keys[i]));
                  den = longint'(bp_keys[i + 1]) - longint'(bp_keys[i]);
                  // sv division truncates toward zero
                  r.coefficient = plit_pkg::VAL_W'(longint'(bp_values[i]) + num / den);
                  r.status      = plit_pkg::STAT_OK;
                  hit           = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      r.entry_count = plit_pkg::ENTRY_W'(bp_count);
      return r;
   endfunction

   // every field random, unused fields included
   function automatic plit_pkg::req_type rand_req();
      plit_pkg::req_type r;
      r.cmd         = plit_pkg::CMD_W'($urandom_range(0, 3));
      r.point_key   = plit_pkg::KEY_W'($urandom);
      r.point_value = plit_pkg::VAL_W'($urandom);
      r.query_angle = plit_pkg::KEY_W'($urandom);
      return r;
   endfunction

   // one beat: optional idle cycles, then hold start until busy is low at an edge
   task automatic send_item(input plit_pkg::req_type item);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         start    <= 1'b0;
         req_data <= rand_req();   // junk on the bus while idle
         @(posedge clock);
      end
      req_data <= item;
      start    <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      pending_results.push_back(predict_interp(item));
      if (item.cmd != CMD_SPARE) begin
         items_accepted++;
      end
   endtask

   task automatic send_cmd(input logic [plit_pkg::CMD_W-1:0] cmd);
      plit_pkg::req_type item;
      item     = rand_req();
      item.cmd = cmd;
      send_item(item);
   endtask

   task automatic send_append(input int key, input int value);
      plit_pkg::req_type item;
      item             = rand_req();
      item.cmd         = plit_pkg::CMD_APPEND;
      item.point_key   = plit_pkg::KEY_W'(key);
      item.point_value = plit_pkg::VAL_W'(value);
      send_item(item);
   endtask

   task automatic send_query(input int angle);
      plit_pkg::req_type item;
      item             = rand_req();
      item.cmd         = plit_pkg::CMD_QUERY;
      item.query_angle = plit_pkg::KEY_W'(angle);
      send_item(item);
   endtask

   // stop sending and let every outstanding result come back
   task automatic wait_results_done();
      int guard;
      start <= 1'b0;
      guard = 0;
      do begin
         @(posedge clock);
         guard++;
      end while (pending_results.size() != 0 && guard < DRAIN_GUARD);
      if (pending_results.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
         pending_results.delete();
      end
   endtask

   // n appends with strictly rising keys; noise_pct mixes in rejected keys
   task automatic load_ascending(input int n, input int max_step, input int noise_pct);
      int k;
      int bad;
      int value;
      int i;
      k = -32768 + int'($urandom_range(0, max_step - 1));
      for (i = 0; i < n; i++) begin
         if (bp_count > 0 && $urandom_range(0, 99) < noise_pct) begin
            // duplicate or lower than the last key held
            bad = int'(bp_keys[bp_count - 1]) - int'($urandom_range(0, 3));
            if (bad < -32768) begin
               bad = bp_keys[bp_count - 1];
            end
            send_append(bad, int'($urandom_range(0, 65535)));
         end
         case ($urandom_range(0, 9))
            0:       value = -32768;
            1:       value = 32767;
            default: value = int'($urandom_range(0, 65535)) - 32768;
         endcase
         send_append(k, value);
         k += 1 + int'($urandom_range(0, max_step - 1));
      end
   endtask

   // mostly inside a held segment, some on keys, some just outside or anywhere
   function automatic int pick_angle();
      int seg;
      int lo;
      int hi;
      int roll;
      roll = $urandom_range(0, 99);
      if (bp_count >= 2 && roll < 80) begin
         seg = $urandom_range(0, bp_count - 2);
         lo  = bp_keys[seg];
         hi  = bp_keys[seg + 1];
         if (roll < 8) begin
            return lo;
         end
         if (roll < 16) begin
            return hi;
         end
         return lo + int'($urandom_range(0, hi - lo));
      end
      if (bp_count >= 1 && roll < 90) begin
         return (roll < 85) ? int'(bp_keys[0]) - 1 : int'(bp_keys[bp_count - 1]) + 1;
      end
      return int'($urandom_range(0, 65535)) - 32768;
   endfunction

   // empty and one-point tables never find a segment
   task automatic test_short_table();
      send_query(0);
      send_cmd(CMD_SPARE);
      send_append(0, 4096);
      send_query(0);
      send_query(-1);
      send_cmd(plit_pkg::CMD_CLEAR);
      send_query(0);
   endtask

   // full-scale keys and values: widest product, both signs of the quotient
   task automatic test_extremes();
      send_append(-32768, -32768);
      send_append(32767, 32767);
      send_query(-32768);
      send_query(32767);
      send_query(-32767);
      send_query(0);
      send_query(32766);
      send_query(-1);
      send_cmd(plit_pkg::CMD_CLEAR);
      send_append(-32768, 32767);
      send_append(32767, -32768);
      send_query(-32767);
      send_query(1);
      send_query(32766);
      send_cmd(CMD_SPARE);
      send_query(0);
   endtask

   // duplicate and lower keys are refused; shared breakpoint and outside angles
   task automatic test_order_rejects();
      send_cmd(plit_pkg::CMD_CLEAR);
      send_append(256, 4096);
      send_append(256, 0);
      send_append(-256, 0);
      send_append(512, -4096);
      send_append(768, 8191);
      send_append(512, 0);
      send_query(512);
      send_query(300);
      send_query(255);
      send_query(769);
      send_query(640);
   endtask

   // fill all entries, refuse further appends, scan to the deepest segment
   task automatic test_full_table();
      int i;
      send_cmd(plit_pkg::CMD_CLEAR);
      load_ascending(TABLE_DEPTH, 65536 / (TABLE_DEPTH + 1), 0);
      send_append(32767, 0);
      // lower key on a full table still reports full
      send_append(-32768, 0);
      send_query(bp_keys[TABLE_DEPTH - 1]);
      send_query(int'(bp_keys[TABLE_DEPTH - 2]) + 1);
      send_query(bp_keys[0]);
      send_query(int'(bp_keys[0]) - 1);
      for (i = 0; i < 6; i++) begin
         send_query(pick_angle());
      end
      send_cmd(plit_pkg::CMD_CLEAR);
      send_query(0);
   endtask

   // random tables of random size, each followed by queries; some pure noise
   task automatic test_random(input int count);
      int target;
      int roll;
      int n;
      int max_step;
      int i;
      target = items_accepted + count;
      while (items_accepted < target) begin
         if ($urandom_range(0, 99) < 85) begin
            send_cmd(plit_pkg::CMD_CLEAR);
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
               n = $urandom_range(0, 1);
            end else if (roll < 70) begin
               n = $urandom_range(2, 8);
            end else if (roll < 90) begin
               n = $urandom_range(9, TABLE_DEPTH - 1);
            end else begin
               n = $urandom_range(TABLE_DEPTH, TABLE_DEPTH + 2);
            end
            // dense keys give tiny denominators
            if ($urandom_range(0, 99) < 20) begin
               max_step = $urandom_range(1, 4);
            end else begin
               max_step = 65536 / (n + 1);
            end
            load_ascending(n, max_step, 8);
            n = $urandom_range(3, 16);
            for (i = 0; i < n; i++) begin
               send_query(pick_angle());
            end
         end else begin
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++) begin
               send_item(rand_req());
            end
         end
      end
   endtask

   // result check: one beat per strobe against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result beat with nothing expected");
         end else begin
            oldest_result = pending_results.pop_front();
            if (rsp_data.coefficient !== oldest_result.coefficient) begin
               report_mismatch($sformatf("coefficient got %0d want %0d",
                  rsp_data.coefficient, oldest_result.coefficient));
            end
            if (rsp_data.status !== oldest_result.status) begin
               report_mismatch($sformatf("status got %0d want %0d",
                  rsp_data.status, oldest_result.status));
            end
            if (rsp_data.entry_count !== oldest_result.entry_count) begin
               report_mismatch($sformatf("entry_count got %0d want %0d",
                  rsp_data.entry_count, oldest_result.entry_count));
            end
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed part with the sender idling now and then
      sender_idle_pct = 38;
      test_short_table();
      test_extremes();
      test_order_rejects();
      test_full_table();
      // hold off until the block has answered everything
      wait_results_done();

      test_random(440);
      sender_idle_pct = 52;
      test_random(440);
      wait_results_done();
      // back-to-back beats
      sender_idle_pct = 0;
      test_random(440);

      wait_results_done();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #10_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
